>>> design/assert_macros.svh
// Assertion macros shared by the dispatcher RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define ASSERT_IMPLIES(label, clock, reset, trig, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle implication");

// Condition holds in the cycle after the trigger.
`define ASSERT_NEXT(label, clock, reset, trig, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> design/rtd_pkg.sv
// Shared types and constants of the render task dispatcher.
// Depends on nothing; imported by every dispatcher module.
package rtd_pkg;

  localparam int UNIT_W = 6;
  localparam int KIND_W = 3;
  localparam int TICK_W = 32;
  localparam int APB_ADDR_W = 1;
  localparam int APB_DATA_W = 32;

  localparam int TRACE_UNITS_DEF = 24;
  localparam int PLOT_UNITS_DEF = 4;
  localparam logic [TICK_W-1:0] TONEMAP_INTERVAL_RESET = 32'd30000;

  // Register addresses on the configuration port.
  localparam logic [APB_ADDR_W-1:0] ADDR_TONEMAP_INTERVAL = 1'b0;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 2;
  localparam int CMD_AW = 1;

  // Task kinds.
  localparam logic [KIND_W-1:0] KIND_SLEEP = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TRACE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PLOT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GATHER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TONEMAP = 3'd4;

  // Command class chosen by the front.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_FREE,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [KIND_W-1:0] kind;
    logic [UNIT_W-1:0] cunit;
    logic [UNIT_W-1:0] funit;
    logic              fvalid;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] other;
    logic              ovalid;
    logic              last;
  } res_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DECIDE,
    B_RUN
  } back_state_t;

endpackage

>>> design/rtd_pool.sv
// Circular FIFO of unit indices with a registered head read.
// Depends on rtd_pkg; an entry never written reads as its own slot number.
module rtd_pool import rtd_pkg::*; #(
  parameter int DEPTH = 4,
  parameter int INIT_FILL = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [UNIT_W-1:0]               push_data,
  input  logic                            pop,
  output logic [UNIT_W-1:0]               head,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [UNIT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [AW-1:0]     head_ptr;
  logic [AW-1:0]     tail_ptr;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     tail_inc;
  logic [AW-1:0]     head_next;
  logic [AW-1:0]     raddr;
  logic              do_push;
  logic              do_pop;
  logic [UNIT_W-1:0] rd_data;
  logic              rd_vld;
  logic [AW-1:0]     rd_addr_q;
  logic              byp;
  logic [UNIT_W-1:0] byp_data;

  // Pushes into a full pool are dropped; pops of an empty pool do nothing.
  assign do_push = push && (cnt != CW'(DEPTH));
  assign do_pop = pop && (cnt != '0);

  assign head_inc = (head_ptr == AW'(DEPTH - 1)) ? '0 : AW'(head_ptr + AW'(1));
  assign tail_inc = (tail_ptr == AW'(DEPTH - 1)) ? '0 : AW'(tail_ptr + AW'(1));
  assign head_next = do_pop ? head_inc : head_ptr;
  assign raddr = rst ? '0 : head_next;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= AW'(INIT_FILL % DEPTH);
      cnt <= CW'(INIT_FILL);
    end else begin
      head_ptr <= head_next;
      if (do_push) begin
        tail_ptr <= tail_inc;
      end
      cnt <= CW'(cnt + CW'(do_push) - CW'(do_pop));
    end
  end

  // Written flags: an unwritten slot holds its reset contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (do_push) begin
      vld[tail_ptr] <= 1'b1;
    end
  end

  // Storage with a registered read of the next head slot.
  always_ff @(posedge clk) begin
    if (do_push && !rst) begin
      mem[tail_ptr] <= push_data;
    end
    rd_data <= mem[raddr];
  end

  // Side information for the read: written flag and same-slot bypass.
  always_ff @(posedge clk) begin
    rd_vld <= !rst && vld[raddr];
    rd_addr_q <= raddr;
    byp <= !rst && do_push && (tail_ptr == raddr);
    byp_data <= push_data;
  end

  assign head = byp ? byp_data : (rd_vld ? rd_data : UNIT_W'(rd_addr_q));
  assign count = cnt;

endmodule

>>> design/rtd_front.sv
// Front of the dispatcher: accepts items, classifies them and queues commands.
// Depends on rtd_pkg.
module rtd_front import rtd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  logic [KIND_W-1:0] completed_kind,
  input  logic [UNIT_W-1:0] completed_unit,
  input  logic [UNIT_W-1:0] freed_unit,
  input  logic              freed_valid,
  input  logic              report_last,
  output logic              busy,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_take
);

  cmd_t              q [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr;
  logic [CMD_AW-1:0] rd_ptr;
  logic [CMD_AW:0]   cnt;
  logic              accept;
  logic              take;
  cmd_t              new_cmd;

  assign busy = (cnt == (CMD_AW + 1)'(CMD_DEPTH));
  assign accept = start && !busy;
  assign cmd_valid = (cnt != '0);
  assign take = cmd_take && cmd_valid;

  // Classify the item: tick, plain report element, or final element.
  always_comb begin
    new_cmd.kind = completed_kind;
    new_cmd.cunit = completed_unit;
    new_cmd.funit = freed_unit;
    new_cmd.fvalid = freed_valid;
    if (!func) begin
      new_cmd.op = OP_TICK;
    end else if (report_last) begin
      new_cmd.op = OP_FINISH;
    end else begin
      new_cmd.op = OP_FREE;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= new_cmd;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= CMD_AW'(wr_ptr + 1'b1);
      end
      if (take) begin
        rd_ptr <= CMD_AW'(rd_ptr + 1'b1);
      end
      cnt <= (CMD_AW + 1)'(cnt + (CMD_AW + 1)'(accept) - (CMD_AW + 1)'(take));
    end
  end

  assign cmd = q[rd_ptr];

endmodule

>>> design/rtd_back.sv
// Back of the dispatcher: unit pools, flags, tick counter and task selection.
// Depends on rtd_pkg and rtd_pool.
module rtd_back import rtd_pkg::*; #(
  parameter int TRACE_UNITS = TRACE_UNITS_DEF,
  parameter int PLOT_UNITS = PLOT_UNITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_take,
  input  logic [TICK_W-1:0] interval,
  output logic              result_valid,
  output res_t              result
);

  localparam int TCW = $clog2(TRACE_UNITS + 1);
  localparam int PCW = $clog2(PLOT_UNITS + 1);
  localparam int RW = (TCW > PCW) ? TCW : PCW;

  back_state_t state;
  back_state_t state_next;

  logic [TICK_W-1:0] ticks;
  logic [TICK_W-1:0] ticks_next;
  logic              gather_free;
  logic              gather_free_next;
  logic              tonemap_free;
  logic              tonemap_free_next;
  logic              image_changed;
  logic              image_changed_next;
  logic [RW-1:0]     remaining;
  logic [RW-1:0]     remaining_next;
  logic              run_gather;
  logic              run_gather_next;
  logic [UNIT_W-1:0] run_unit;
  logic [UNIT_W-1:0] run_unit_next;
  logic              result_valid_next;
  res_t              result_next;

  logic              ft_push;
  logic              ft_pop;
  logic [UNIT_W-1:0] ft_head;
  logic [TCW-1:0]    ft_cnt;
  logic              dt_push;
  logic              dt_pop;
  logic [UNIT_W-1:0] dt_head;
  logic [TCW-1:0]    dt_cnt;
  logic              fp_push;
  logic              fp_pop;
  logic [UNIT_W-1:0] fp_head;
  logic [PCW-1:0]    fp_cnt;
  logic              dp_push;
  logic              dp_pop;
  logic [UNIT_W-1:0] dp_head;
  logic [PCW-1:0]    dp_cnt;

  logic              refresh;
  logic              take_tonemap;
  logic              take_gather;
  logic              take_plot;
  logic              take_trace;
  logic [TCW-1:0]    dt_half;
  logic [TCW-1:0]    plot_n;
  logic              run_last;

  // Unit pools.
  rtd_pool #(.DEPTH(TRACE_UNITS), .INIT_FILL(TRACE_UNITS)) u_free_trace (
    .clk(clk), .rst(rst), .push(ft_push), .push_data(cmd.funit), .pop(ft_pop),
    .head(ft_head), .count(ft_cnt)
  );

  rtd_pool #(.DEPTH(TRACE_UNITS), .INIT_FILL(0)) u_done_trace (
    .clk(clk), .rst(rst), .push(dt_push), .push_data(cmd.cunit), .pop(dt_pop),
    .head(dt_head), .count(dt_cnt)
  );

  rtd_pool #(.DEPTH(PLOT_UNITS), .INIT_FILL(PLOT_UNITS)) u_free_plot (
    .clk(clk), .rst(rst), .push(fp_push), .push_data(cmd.funit), .pop(fp_pop),
    .head(fp_head), .count(fp_cnt)
  );

  rtd_pool #(.DEPTH(PLOT_UNITS), .INIT_FILL(0)) u_done_plot (
    .clk(clk), .rst(rst), .push(dp_push), .push_data(cmd.cunit), .pop(dp_pop),
    .head(dp_head), .count(dp_cnt)
  );

  // Selection terms in priority order.
  assign refresh = (ticks > interval);
  assign take_tonemap = refresh && image_changed && gather_free && tonemap_free;
  assign dt_half = dt_cnt >> 1;
  assign plot_n = (dt_half == '0) ? TCW'(1) : dt_half;
  assign take_trace = (ft_cnt != '0);
  always_comb begin
    take_gather = 1'b0;
    take_plot = 1'b0;
    if (refresh && !image_changed && gather_free && (dp_cnt != '0)) begin
      take_gather = 1'b1;
    end else if ((dt_cnt > TCW'(TRACE_UNITS / 2)) && (fp_cnt != '0)) begin
      take_plot = 1'b1;
    end else if (!take_trace) begin
      if ((fp_cnt != '0) && (dt_cnt != '0)) begin
        take_plot = 1'b1;
      end else if (gather_free && (dp_cnt != '0)) begin
        take_gather = 1'b1;
      end
    end
  end

  assign run_last = (remaining == RW'(1));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, pool controls and result formation.
  always_comb begin
    state_next = state;
    ticks_next = ticks;
    gather_free_next = gather_free;
    tonemap_free_next = tonemap_free;
    image_changed_next = image_changed;
    remaining_next = remaining;
    run_gather_next = run_gather;
    run_unit_next = run_unit;
    result_valid_next = 1'b0;
    result_next = result;
    cmd_take = 1'b0;
    ft_push = 1'b0;
    ft_pop = 1'b0;
    dt_push = 1'b0;
    dt_pop = 1'b0;
    fp_push = 1'b0;
    fp_pop = 1'b0;
    dp_push = 1'b0;
    dp_pop = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          unique case (cmd.op) inside
            OP_TICK: begin
              if (ticks != '1) begin
                ticks_next = ticks + 1'b1;
              end
            end
            OP_FREE, OP_FINISH: begin
              // A freed unit goes back to its free pool at once.
              if (cmd.fvalid) begin
                ft_push = (cmd.kind == KIND_PLOT);
                fp_push = (cmd.kind == KIND_GATHER);
              end
              if (cmd.op == OP_FINISH) begin
                // Retire the finished task, then choose the next one.
                case (cmd.kind)
                  KIND_TRACE: dt_push = 1'b1;
                  KIND_PLOT: dp_push = 1'b1;
                  KIND_GATHER: begin
                    gather_free_next = 1'b1;
                    image_changed_next = 1'b1;
                  end
                  KIND_TONEMAP: begin
                    gather_free_next = 1'b1;
                    tonemap_free_next = 1'b1;
                    image_changed_next = 1'b0;
                    ticks_next = '0;
                  end
                  default: ;
                endcase
                state_next = B_DECIDE;
              end
            end
            default: ;
          endcase
        end
      end
      B_DECIDE: begin
        if (take_tonemap) begin
          gather_free_next = 1'b0;
          tonemap_free_next = 1'b0;
          result_valid_next = 1'b1;
          result_next = '{kind: KIND_TONEMAP, unit: '0, other: '0, ovalid: 1'b0, last: 1'b1};
          state_next = B_IDLE;
        end else if (take_gather) begin
          gather_free_next = 1'b0;
          run_gather_next = 1'b1;
          run_unit_next = '0;
          remaining_next = RW'(dp_cnt);
          state_next = B_RUN;
        end else if (take_plot) begin
          fp_pop = 1'b1;
          run_gather_next = 1'b0;
          run_unit_next = fp_head;
          remaining_next = RW'(plot_n);
          state_next = B_RUN;
        end else if (take_trace) begin
          ft_pop = 1'b1;
          result_valid_next = 1'b1;
          result_next = '{kind: KIND_TRACE, unit: ft_head, other: '0, ovalid: 1'b0, last: 1'b1};
          state_next = B_IDLE;
        end else begin
          result_valid_next = 1'b1;
          result_next = '{kind: KIND_SLEEP, unit: '0, other: '0, ovalid: 1'b0, last: 1'b1};
          state_next = B_IDLE;
        end
      end
      B_RUN: begin
        // One handed unit per cycle from the matching done pool.
        dt_pop = !run_gather;
        dp_pop = run_gather;
        result_valid_next = 1'b1;
        result_next.kind = run_gather ? KIND_GATHER : KIND_PLOT;
        result_next.unit = run_unit;
        result_next.other = run_gather ? dp_head : dt_head;
        result_next.ovalid = 1'b1;
        result_next.last = run_last;
        remaining_next = RW'(remaining - 1'b1);
        if (run_last) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Flags, counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= '0;
      gather_free <= 1'b1;
      tonemap_free <= 1'b1;
      image_changed <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      ticks <= ticks_next;
      gather_free <= gather_free_next;
      tonemap_free <= tonemap_free_next;
      image_changed <= image_changed_next;
      result_valid <= result_valid_next;
    end
  end

  // Run bookkeeping and result payload.
  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    run_gather <= run_gather_next;
    run_unit <= run_unit_next;
    result <= result_next;
  end

endmodule

>>> design/render_task_dispatcher.sv
// Top level of the render task dispatcher: configuration register and wiring.
// Depends on rtd_pkg, rtd_front, rtd_back and assert_macros.svh.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+------------------------------------------
//  items in | start, busy (taken: start&!busy)| func, completed_kind, completed_unit,
//           |                                 | freed_unit, freed_valid, report_last
//  results  | result_valid, one cycle each    | task_kind, task_unit, other_unit,
//           |                                 | other_valid, task_last
//  config   | APB write, pready tied high     | paddr, pwdata, prdata
//
// A tick or a non-final report element is handled in the idle state alone. A
// final element is retired there, then the next task is selected in the decide
// state; a tonemap, trace or sleep result leaves from that selection, while a
// plot or gather run then pops one done unit a cycle from its pool, one for each result item.
// Items wait in a two-entry command queue; busy is high while it is full.
// After the synchronous reset the pools are ready at once, with no clearing pass.
// Results cannot be stalled by the receiver.
`include "assert_macros.svh"

module render_task_dispatcher import rtd_pkg::*; #(
  parameter int TRACE_UNITS = TRACE_UNITS_DEF,
  parameter int PLOT_UNITS = PLOT_UNITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func,
  input  logic [KIND_W-1:0]     completed_kind,
  input  logic [UNIT_W-1:0]     completed_unit,
  input  logic [UNIT_W-1:0]     freed_unit,
  input  logic                  freed_valid,
  input  logic                  report_last,
  output logic                  result_valid,
  output logic [KIND_W-1:0]     task_kind,
  output logic [UNIT_W-1:0]     task_unit,
  output logic [UNIT_W-1:0]     other_unit,
  output logic                  other_valid,
  output logic                  task_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [TICK_W-1:0] tonemap_interval;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_take;
  res_t              result;
  logic              accept;

  assign pready = 1'b1;
  assign accept = start && !busy;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tonemap_interval <= TONEMAP_INTERVAL_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_TONEMAP_INTERVAL)) begin
      tonemap_interval <= pwdata;
    end
  end

  assign prdata = (paddr == ADDR_TONEMAP_INTERVAL) ? tonemap_interval : '0;

  rtd_front u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .func(func),
    .completed_kind(completed_kind),
    .completed_unit(completed_unit),
    .freed_unit(freed_unit),
    .freed_valid(freed_valid),
    .report_last(report_last),
    .busy(busy),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_take(cmd_take)
  );

  rtd_back #(.TRACE_UNITS(TRACE_UNITS), .PLOT_UNITS(PLOT_UNITS)) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_take(cmd_take),
    .interval(tonemap_interval),
    .result_valid(result_valid),
    .result(result)
  );

  assign task_kind = result.kind;
  assign task_unit = result.unit;
  assign other_unit = result.other;
  assign other_valid = result.ovalid;
  assign task_last = result.last;

  // The back end returns to idle after a run, so results never run together.
  `ASSERT_NEXT(a_gap_after_last, clk, rst, result_valid && task_last, !result_valid)
  // Only plot and gather tasks span several result items.
  `ASSERT_IMPLIES(a_multi_kind, clk, rst, result_valid && !task_last, (task_kind == KIND_PLOT) || (task_kind == KIND_GATHER))
  // Plot and gather items always hand on a done unit; other kinds never do.
  `ASSERT_IMPLIES(a_other_valid, clk, rst, result_valid, other_valid == ((task_kind == KIND_PLOT) || (task_kind == KIND_GATHER)))
  // An accepted item is waiting in the command queue on the next cycle.
  `ASSERT_NEXT(a_queued, clk, rst, accept, cmd_valid)

endmodule

>>> tb/sv/rtd_dispatch_checker.sv
// Checker of the render task dispatcher: follows accepted items and register writes,
// keeps its own copy of the unit pools and flags, and compares every result item.
// Depends on rtd_pkg for the field widths, task kinds and the result record.
module rtd_dispatch_checker import rtd_pkg::*; #(
  parameter int TRACE_UNITS = TRACE_UNITS_DEF,
  parameter int PLOT_UNITS = PLOT_UNITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  func,
  input  logic [KIND_W-1:0]     completed_kind,
  input  logic [UNIT_W-1:0]     completed_unit,
  input  logic [UNIT_W-1:0]     freed_unit,
  input  logic                  freed_valid,
  input  logic                  report_last,
  input  logic                  result_valid,
  input  logic [KIND_W-1:0]     task_kind,
  input  logic [UNIT_W-1:0]     task_unit,
  input  logic [UNIT_W-1:0]     other_unit,
  input  logic                  other_valid,
  input  logic                  task_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatch_count,
  output int                    tasks_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the dispatcher state.
  logic [UNIT_W-1:0] free_trace[$];
  logic [UNIT_W-1:0] done_trace[$];
  logic [UNIT_W-1:0] free_plot[$];
  logic [UNIT_W-1:0] done_plot[$];
  logic              gather_idle;
  logic              tonemap_idle;
  logic              image_dirty;
  logic [TICK_W-1:0] ticks_since_tonemap;
  logic [TICK_W-1:0] tonemap_interval;

  // Result items still owed by the block, oldest first.
  res_t expected_tasks[$];

  initial begin
    mismatch_count = 0;
    tasks_pending = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void reset_pools();
    free_trace.delete();
    done_trace.delete();
    free_plot.delete();
    done_plot.delete();
    for (int i = 0; i < TRACE_UNITS; i++) free_trace.insert(free_trace.size(), UNIT_W'(i));
    for (int i = 0; i < PLOT_UNITS; i++) free_plot.insert(free_plot.size(), UNIT_W'(i));
    gather_idle = 1'b1;
    tonemap_idle = 1'b1;
    image_dirty = 1'b0;
    ticks_since_tonemap = '0;
    tonemap_interval = TONEMAP_INTERVAL_RESET;
    expected_tasks.delete();
  endfunction

  function automatic void owe_result(input logic [KIND_W-1:0] kind,
                                     input logic [UNIT_W-1:0] unit,
                                     input logic [UNIT_W-1:0] other,
                                     input logic ovalid, input logic last);
    res_t r;
    r.kind = kind;
    r.unit = unit;
    r.other = other;
    r.ovalid = ovalid;
    r.last = last;
    expected_tasks.insert(expected_tasks.size(), r);
  endfunction

  // A plot task takes one plot unit and half the done trace units (at least one).
  function automatic void owe_plot_task();
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] other;
    int n;
    unit = '0;
    if (free_plot.size() != 0) begin
      unit = free_plot[0];
      free_plot.delete(0);
    end
    n = done_trace.size() / 2;
    if (n < 1) n = 1;
    if (n > done_trace.size()) n = done_trace.size();
    if (n == 0) owe_result(KIND_PLOT, unit, '0, 1'b0, 1'b1);
    for (int i = 0; i < n; i++) begin
      other = done_trace[0];
      done_trace.delete(0);
      owe_result(KIND_PLOT, unit, other, 1'b1, i == n - 1);
    end
  endfunction

  // A gather task takes every done plot unit.
  function automatic void owe_gather_task();
    logic [UNIT_W-1:0] other;
    int n;
    n = done_plot.size();
    gather_idle = 1'b0;
    if (n == 0) owe_result(KIND_GATHER, '0, '0, 1'b0, 1'b1);
    for (int i = 0; i < n; i++) begin
      other = done_plot[0];
      done_plot.delete(0);
      owe_result(KIND_GATHER, '0, other, 1'b1, i == n - 1);
    end
  endfunction

  // Pick the next task in priority order.
  function automatic void dispatch_next_task();
    logic [UNIT_W-1:0] unit;
    if (ticks_since_tonemap > tonemap_interval) begin
      if (image_dirty) begin
        if (gather_idle && tonemap_idle) begin
          gather_idle = 1'b0;
          tonemap_idle = 1'b0;
          owe_result(KIND_TONEMAP, '0, '0, 1'b0, 1'b1);
          return;
        end
      end else if (gather_idle && done_plot.size() != 0) begin
        owe_gather_task();
        return;
      end
    end
    if (done_trace.size() > TRACE_UNITS / 2 && free_plot.size() != 0) begin
      owe_plot_task();
      return;
    end
    if (free_trace.size() != 0) begin
      unit = free_trace[0];
      free_trace.delete(0);
      owe_result(KIND_TRACE, unit, '0, 1'b0, 1'b1);
      return;
    end
    if (free_plot.size() != 0 && done_trace.size() != 0) begin
      owe_plot_task();
      return;
    end
    if (gather_idle && done_plot.size() != 0) begin
      owe_gather_task();
      return;
    end
    owe_result(KIND_SLEEP, '0, '0, 1'b0, 1'b1);
  endfunction

  // Apply one accepted item: a tick, or one element of a completion report.
  function automatic void apply_item();
    if (!func) begin
      if (ticks_since_tonemap != '1) ticks_since_tonemap++;
      return;
    end
    if (freed_valid) begin
      case (completed_kind)
        KIND_PLOT:
          if (free_trace.size() < TRACE_UNITS) free_trace.insert(free_trace.size(), freed_unit);
        KIND_GATHER:
          if (free_plot.size() < PLOT_UNITS) free_plot.insert(free_plot.size(), freed_unit);
        default: ;
      endcase
    end
    if (!report_last) return;
    case (completed_kind)
      KIND_TRACE:
        if (done_trace.size() < TRACE_UNITS) done_trace.insert(done_trace.size(), completed_unit);
      KIND_PLOT:
        if (done_plot.size() < PLOT_UNITS) done_plot.insert(done_plot.size(), completed_unit);
      KIND_GATHER: begin
        gather_idle = 1'b1;
        image_dirty = 1'b1;
      end
      KIND_TONEMAP: begin
        gather_idle = 1'b1;
        tonemap_idle = 1'b1;
        image_dirty = 1'b0;
        ticks_since_tonemap = '0;
      end
      default: ;
    endcase
    dispatch_next_task();
  endfunction

  // Everything is sampled at the rising edge, before the edge's own updates land.
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      reset_pools();
    end else begin
      // Compare a result item against the oldest one owed.
      if (result_valid) begin
        if (expected_tasks.size() == 0) begin
          report_mismatch($sformatf("result item with none expected: kind %0d unit %0d",
                                    task_kind, task_unit));
        end else begin
          want = expected_tasks[0];
          expected_tasks.delete(0);
          if (task_kind !== want.kind)
            report_mismatch($sformatf("task_kind got %0d, expected %0d", task_kind,
                                      want.kind));
          if (task_unit !== want.unit)
            report_mismatch($sformatf("task_unit got %0d, expected %0d", task_unit,
                                      want.unit));
          if (other_unit !== want.other)
            report_mismatch($sformatf("other_unit got %0d, expected %0d", other_unit,
                                      want.other));
          if (other_valid !== want.ovalid)
            report_mismatch($sformatf("other_valid got %0d, expected %0d", other_valid,
                                      want.ovalid));
          if (task_last !== want.last)
            report_mismatch($sformatf("task_last got %0d, expected %0d", task_last,
                                      want.last));
        end
      end
      // Register writes.
      if (psel && penable && pwrite && pready && paddr == ADDR_TONEMAP_INTERVAL)
        tonemap_interval = pwdata;
      // Accepted items.
      if (start && !busy) apply_item();
    end
    tasks_pending <= expected_tasks.size();
  end

endmodule

>>> tb/sv/render_task_dispatcher_tb.sv
// Testbench top of the render task dispatcher: drives items and register writes,
// reports finished tasks back as the block hands them out, and prints the verdict.
// Depends on rtd_pkg, render_task_dispatcher and rtd_dispatch_checker.
module render_task_dispatcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtd_pkg::*;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;
  localparam int MAX_HANDED = 16;
  localparam int POOL_SLOTS = 64;
  localparam int RING_SLOTS = 256;
  localparam int DRAIN_CYCLES = 12;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  func;
  logic [KIND_W-1:0]     completed_kind;
  logic [UNIT_W-1:0]     completed_unit;
  logic [UNIT_W-1:0]     freed_unit;
  logic                  freed_valid;
  logic                  report_last;
  logic                  result_valid;
  logic [KIND_W-1:0]     task_kind;
  logic [UNIT_W-1:0]     task_unit;
  logic [UNIT_W-1:0]     other_unit;
  logic                  other_valid;
  logic                  task_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatch_count;
  int                    tasks_pending;

  render_task_dispatcher u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .completed_kind(completed_kind), .completed_unit(completed_unit),
    .freed_unit(freed_unit), .freed_valid(freed_valid), .report_last(report_last),
    .result_valid(result_valid), .task_kind(task_kind), .task_unit(task_unit),
    .other_unit(other_unit), .other_valid(other_valid), .task_last(task_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  rtd_dispatch_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .completed_kind(completed_kind), .completed_unit(completed_unit),
    .freed_unit(freed_unit), .freed_valid(freed_valid), .report_last(report_last),
    .result_valid(result_valid), .task_kind(task_kind), .task_unit(task_unit),
    .other_unit(other_unit), .other_valid(other_valid), .task_last(task_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .mismatch_count(mismatch_count), .tasks_pending(tasks_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Tasks handed out by the block are logged into a ring, so the stimulus can
  // report them finished later. Sleep tasks need no report and are skipped.
  logic [KIND_W-1:0] ring_kind [RING_SLOTS];
  logic [UNIT_W-1:0] ring_unit [RING_SLOTS];
  int                ring_n [RING_SLOTS];
  logic [UNIT_W-1:0] ring_other [RING_SLOTS][MAX_HANDED];
  logic [7:0]        ring_wr = '0;
  int                run_n = 0;

  always @(posedge clk) begin
    if (rst) begin
      ring_wr <= '0;
      run_n <= 0;
    end else if (result_valid) begin
      if (other_valid && run_n < MAX_HANDED) ring_other[ring_wr][run_n] <= other_unit;
      if (!task_last) begin
        run_n <= run_n + other_valid;
      end else begin
        run_n <= 0;
        if (task_kind != KIND_SLEEP && task_kind <= KIND_TONEMAP) begin
          ring_kind[ring_wr] <= task_kind;
          ring_unit[ring_wr] <= task_unit;
          ring_n[ring_wr] <= run_n + other_valid;
          ring_wr <= ring_wr + 8'd1;
        end
      end
    end
  end

  // Tasks still running in the imagined renderer; owned by the stimulus process.
  logic [KIND_W-1:0] job_kind [POOL_SLOTS];
  logic [UNIT_W-1:0] job_unit [POOL_SLOTS];
  int                job_n [POOL_SLOTS];
  logic [UNIT_W-1:0] job_other [POOL_SLOTS][MAX_HANDED];
  int                job_count = 0;
  logic [7:0]        ring_rd = '0;
  int                items_sent = 0;
  int                gap_pct = 0;

  function automatic logic [UNIT_W-1:0] rand_unit();
    return UNIT_W'($urandom);
  endfunction

  // Drive one item and hold it until the block takes it.
  task automatic send_item(input logic f, input logic [KIND_W-1:0] kind,
                           input logic [UNIT_W-1:0] cunit, input logic [UNIT_W-1:0] funit,
                           input logic fvalid, input logic last);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    completed_kind <= kind;
    completed_unit <= cunit;
    freed_unit <= funit;
    freed_valid <= fvalid;
    report_last <= last;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, KIND_W'($urandom), rand_unit(), rand_unit(), 1'($urandom),
              1'($urandom));
  endtask

  // Wait until every owed result has come and queued ticks have drained.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (tasks_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic void collect_handed_tasks();
    while (ring_rd != ring_wr) begin
      if (job_count < POOL_SLOTS) begin
        job_kind[job_count] = ring_kind[ring_rd];
        job_unit[job_count] = ring_unit[ring_rd];
        job_n[job_count] = ring_n[ring_rd] > MAX_HANDED ? MAX_HANDED : ring_n[ring_rd];
        for (int j = 0; j < MAX_HANDED; j++) job_other[job_count][j] = ring_other[ring_rd][j];
        job_count++;
      end
      ring_rd++;
    end
  endfunction

  // Report one running task as finished; handed units come back last first.
  task automatic finish_job();
    int pick;
    int n;
    logic [KIND_W-1:0] kind;
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] handed [MAX_HANDED];
    pick = $urandom_range(job_count - 1);
    kind = job_kind[pick];
    unit = job_unit[pick];
    n = job_n[pick];
    for (int j = 0; j < MAX_HANDED; j++) handed[j] = job_other[pick][j];
    job_count--;
    job_kind[pick] = job_kind[job_count];
    job_unit[pick] = job_unit[job_count];
    job_n[pick] = job_n[job_count];
    for (int j = 0; j < MAX_HANDED; j++) job_other[pick][j] = job_other[job_count][j];
    if (kind == KIND_TRACE || kind == KIND_TONEMAP) begin
      // Freed units on these kinds are ignored by the block.
      send_item(FUNC_REPORT, kind, unit, rand_unit(), 1'($urandom), 1'b1);
    end else if (n == 0) begin
      send_item(FUNC_REPORT, kind, unit, '0, 1'b0, 1'b1);
    end else begin
      for (int i = n - 1; i >= 0; i--) begin
        if ($urandom_range(9) == 0) send_tick();
        send_item(FUNC_REPORT, kind, unit, handed[i], 1'b1, i == 0);
      end
    end
  endtask

  // Mostly well-formed reports of running tasks, with ticks and noise mixed in.
  task automatic run_random(input int count);
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < count) begin
      collect_handed_tasks();
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_tick();
      end else if (pick < 35) begin
        send_item(1'($urandom), KIND_W'($urandom), rand_unit(), rand_unit(),
                  1'($urandom), 1'($urandom));
      end else if (pick < 40 || job_count == 0) begin
        send_item(FUNC_REPORT, KIND_SLEEP, rand_unit(), rand_unit(), 1'($urandom), 1'b1);
      end else begin
        finish_job();
      end
      if ($urandom_range(99) < 2) wait_idle();
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_TICK;
    completed_kind = KIND_SLEEP;
    completed_unit = '0;
    freed_unit = '0;
    freed_valid = 1'b0;
    report_last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_TONEMAP_INTERVAL;
    pwdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset interval.
    gap_pct = 14;
    send_item(FUNC_REPORT, KIND_SLEEP, '0, '0, 1'b0, 1'b1);
    // Unknown kinds behave as sleep; their freed units are ignored.
    send_item(FUNC_REPORT, KIND_W'(7), '1, '1, 1'b1, 1'b1);
    send_item(FUNC_REPORT, KIND_W'(5), '0, '1, 1'b1, 1'b1);
    send_item(FUNC_TICK, '1, '1, '1, 1'b1, 1'b1);
    send_item(FUNC_TICK, '0, '0, '0, 1'b0, 1'b0);
    // Trace done on a unit outside the pool, with a freed unit to ignore.
    send_item(FUNC_REPORT, KIND_TRACE, '1, '0, 1'b1, 1'b1);
    // Freed plot unit into a full plot pool is dropped.
    send_item(FUNC_REPORT, KIND_GATHER, '0, '1, 1'b1, 1'b0);
    // Freed trace unit outside the pool, in a report that is not final.
    send_item(FUNC_REPORT, KIND_PLOT, 6'd5, '1, 1'b1, 1'b0);
    send_item(FUNC_REPORT, KIND_PLOT, 6'd5, '0, 1'b0, 1'b0);
    send_item(FUNC_REPORT, KIND_TONEMAP, '0, '0, 1'b0, 1'b1);
    send_item(FUNC_REPORT, KIND_GATHER, '0, '0, 1'b0, 1'b1);

    // Interval of one: a changed image calls for a tonemap.
    wait_idle();
    apb_write(ADDR_TONEMAP_INTERVAL, 32'd1);
    repeat (3) send_tick();
    send_item(FUNC_REPORT, KIND_SLEEP, '0, '0, 1'b0, 1'b1);
    send_item(FUNC_REPORT, KIND_TONEMAP, '0, '0, 1'b0, 1'b1);
    // Clean image with a done plot unit calls for a gather.
    repeat (2) send_tick();
    send_item(FUNC_REPORT, KIND_PLOT, 6'd2, '0, 1'b0, 1'b1);
    send_item(FUNC_REPORT, KIND_GATHER, '0, 6'd2, 1'b1, 1'b1);

    // Random phases: light gaps, heavy gaps, then back to back.
    wait_idle();
    apb_write(ADDR_TONEMAP_INTERVAL, APB_DATA_W'($urandom_range(2, 6)));
    gap_pct = 14;
    run_random(75);
    wait_idle();
    apb_write(ADDR_TONEMAP_INTERVAL, '1);
    gap_pct = 85;
    run_random(70);
    wait_idle();
    apb_write(ADDR_TONEMAP_INTERVAL, 32'd1);
    gap_pct = 0;
    run_random(75);
    wait_idle();

    if (mismatch_count == 0 && tasks_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/rtd_pkg.sv
design/rtd_pool.sv
design/rtd_front.sv
design/rtd_back.sv
design/render_task_dispatcher.sv
tb/sv/rtd_dispatch_checker.sv
tb/sv/render_task_dispatcher_tb.sv
